// ===== rtl/vpa_pkg.sv =====
// Shared types and codes for the variable partition allocator.
// Used by the channel interfaces and the allocator top level.
package vpa_pkg;

  localparam int LEN_W = 16;
  localparam int OWN_W = 4;
  localparam int SEG_W = 3;

  localparam logic [1:0] K_ALLOC = 2'd0;
  localparam logic [1:0] K_FREE  = 2'd1;
  localparam logic [1:0] K_TOUCH = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] R_EVICT = 2'd0;
  localparam logic [1:0] R_ALLOC = 2'd1;
  localparam logic [1:0] R_FREE  = 2'd2;
  localparam logic [1:0] R_TOUCH = 2'd3;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef struct packed {
    logic             used;
    logic [OWN_W-1:0] owner;
    logic [SEG_W-1:0] seg;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] len;
  } tbl_entry_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic             status;
    logic [LEN_W-1:0] address;
    logic [OWN_W-1:0] owner_out;
    logic [SEG_W-1:0] segment_out;
    logic [LEN_W-1:0] length_out;
    logic             last;
  } res_t;

endpackage

// ===== rtl/vpa_ifs.sv =====
// Valid/ready channel interfaces of the variable partition allocator.
// Depends on vpa_pkg for field widths.
interface vpa_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [vpa_pkg::OWN_W-1:0]      process_id;
  logic [vpa_pkg::SEG_W-1:0]      segment_index;
  logic [vpa_pkg::LEN_W-1:0]      request_length;
  logic [1:0]                     fit_mode;
  modport source(output valid, kind, process_id, segment_index, request_length, fit_mode,
                 input ready);
  modport sink(input valid, kind, process_id, segment_index, request_length, fit_mode,
               output ready);
endinterface

interface vpa_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                result_kind;
  logic                      status;
  logic [vpa_pkg::LEN_W-1:0] address;
  logic [vpa_pkg::OWN_W-1:0] owner_out;
  logic [vpa_pkg::SEG_W-1:0] segment_out;
  logic [vpa_pkg::LEN_W-1:0] length_out;
  logic                      last;
  modport source(output valid, result_kind, status, address, owner_out, segment_out,
                 length_out, last, input ready);
  modport sink(input valid, result_kind, status, address, owner_out, segment_out,
               length_out, last, output ready);
endinterface

interface vpa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [vpa_pkg::LEN_W-1:0] total_size;
  modport source(output valid, total_size, input ready);
  modport sink(input valid, total_size, output ready);
endinterface

// ===== rtl/vpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/variable_partition_allocator.sv =====
// Variable partition allocator: partition table in two ping-pong RAMs, use counts in a RAM.
// Depends on vpa_pkg, vpa_ifs and vpa_ram. One item at a time.
// Touch updates one use count; free rewrites the table, freeing and merging partitions.
// Allocate takes an exact fit in place or splits the pick in a table rewrite; failing that it
// compacts and rescans, then evicts least-used entries one by one; output stalls hold it.
// Reset and each total_size write start a clear of all MAX_PROCS*MAX_SEGS use counts.
module variable_partition_allocator #(
  parameter int MAX_PARTITIONS = 16,
  parameter int MAX_PROCS      = 16,
  parameter int MAX_SEGS       = 8,
  parameter int ADDR_BITS      = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  vpa_in_if.sink       in_ch,
  vpa_out_if.source    out_ch,
  vpa_cfg_if.sink      cfg_ch
);

  localparam int PI_W     = $clog2(MAX_PARTITIONS);
  localparam int CNT_W    = $clog2(MAX_PARTITIONS + 1);
  localparam int UC_DEPTH = MAX_PROCS * MAX_SEGS;
  localparam int UC_AW    = (UC_DEPTH > 1) ? $clog2(UC_DEPTH) : 1;
  localparam int ENT_W    = $bits(vpa_pkg::tbl_entry_t);
  localparam int LW       = vpa_pkg::LEN_W;
  localparam logic [LW-1:0] ADDR_MASK =
    (ADDR_BITS >= LW) ? {LW{1'b1}} : LW'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTITIONS);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_RD     = 10'b0000000100,
    ST_DATA   = 10'b0000001000,
    ST_USE    = 10'b0000010000,
    ST_SPLIT2 = 10'b0000100000,
    ST_END    = 10'b0001000000,
    ST_UPD_RD = 10'b0010000000,
    ST_UPD_WR = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    PASS_SCAN    = 2'd0,
    PASS_COMPACT = 2'd1,
    PASS_SPLIT   = 2'd2,
    PASS_MERGE   = 2'd3
  } pass_t;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_AFTER = 2'd1,
    PH_EVICT = 2'd2,
    PH_FINAL = 2'd3
  } phase_t;

  function automatic logic [UC_AW-1:0] uidx(input logic [vpa_pkg::OWN_W-1:0] p,
                                            input logic [vpa_pkg::SEG_W-1:0] s);
    return UC_AW'(int'(p) * MAX_SEGS + int'(s));
  endfunction

  state_t state_r, state_nxt;
  pass_t  pass_r, pass_nxt;
  phase_t phase_r, phase_nxt;
  logic   cur_r, cur_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, rd_r, rd_nxt, j_r, j_nxt;
  logic [UC_AW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] total_r, total_nxt;

  logic [1:0]                kind_r, kind_nxt, mode_r, mode_nxt;
  logic [vpa_pkg::OWN_W-1:0] pid_r, pid_nxt;
  logic [vpa_pkg::SEG_W-1:0] seg_r, seg_nxt;
  logic [LW-1:0]             req_r, req_nxt;

  vpa_pkg::tbl_entry_t ent_r, ent_nxt, min_ent_r, min_ent_nxt, hold_r, hold_nxt;
  logic            hold_v_r, hold_v_nxt;
  logic            conflict_r, conflict_nxt;
  logic            pick_found_r, pick_found_nxt;
  logic [PI_W-1:0] pick_idx_r, pick_idx_nxt, min_idx_r, min_idx_nxt;
  logic [LW-1:0]   pick_start_r, pick_start_nxt, pick_len_r, pick_len_nxt;
  logic [LW-1:0]   fs_r, fs_nxt, addr_r, addr_nxt, rel_r, rel_nxt;
  logic            min_found_r, min_found_nxt;
  logic [7:0]      min_uc_r, min_uc_nxt;

  vpa_pkg::res_t em_r, em_nxt, out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [ENT_W-1:0]    rdata0, rdata1;
  vpa_pkg::tbl_entry_t tdat, tw_data, e;
  logic                tw_en, tw_bank;
  logic [PI_W-1:0]     tw_addr;
  logic [UC_AW-1:0]    ur_addr, uw_addr;
  logic                uw_en;
  logic [7:0]          uw_data, urdata, newc;
  logic                go_pass, last_rd, pid_ok, seg_ok, in_xfer, cfg_xfer, evict_chk;
  pass_t               go_type;

  assign tdat     = vpa_pkg::tbl_entry_t'(cur_r ? rdata1 : rdata0);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;
  assign last_rd  = (rd_r + CNT_W'(1)) == count_r;

  vpa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_PARTITIONS)) u_tbl0 (
    .clk(clk), .we(tw_en && !tw_bank), .waddr(tw_addr), .wdata(ENT_W'(tw_data)),
    .raddr(rd_r[PI_W-1:0]), .rdata(rdata0)
  );

  vpa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_PARTITIONS)) u_tbl1 (
    .clk(clk), .we(tw_en && tw_bank), .waddr(tw_addr), .wdata(ENT_W'(tw_data)),
    .raddr(rd_r[PI_W-1:0]), .rdata(rdata1)
  );

  vpa_ram #(.WIDTH(8), .DEPTH(UC_DEPTH)) u_use (
    .clk(clk), .we(uw_en), .waddr(uw_addr), .wdata(uw_data),
    .raddr(ur_addr), .rdata(urdata)
  );

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    phase_nxt      = phase_r;
    cur_nxt        = cur_r;
    count_nxt      = count_r;
    rd_nxt         = rd_r;
    j_nxt          = j_r;
    clr_nxt        = clr_r;
    total_nxt      = total_r;
    kind_nxt       = kind_r;
    mode_nxt       = mode_r;
    pid_nxt        = pid_r;
    seg_nxt        = seg_r;
    req_nxt        = req_r;
    ent_nxt        = ent_r;
    min_ent_nxt    = min_ent_r;
    hold_nxt       = hold_r;
    hold_v_nxt     = hold_v_r;
    conflict_nxt   = conflict_r;
    pick_found_nxt = pick_found_r;
    pick_idx_nxt   = pick_idx_r;
    pick_start_nxt = pick_start_r;
    pick_len_nxt   = pick_len_r;
    fs_nxt         = fs_r;
    addr_nxt       = addr_r;
    rel_nxt        = rel_r;
    min_found_nxt  = min_found_r;
    min_idx_nxt    = min_idx_r;
    min_uc_nxt     = min_uc_r;
    em_nxt         = em_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    tw_en          = 1'b0;
    tw_bank        = ~cur_r;
    tw_addr        = j_r[PI_W-1:0];
    tw_data        = '0;
    e              = tdat;
    uw_en          = 1'b0;
    uw_addr        = '0;
    uw_data        = '0;
    ur_addr        = uidx(pid_r, seg_r);
    newc           = (urdata == 8'd255) ? urdata : urdata + 8'd1;
    go_pass        = 1'b0;
    go_type        = PASS_SCAN;
    evict_chk      = 1'b0;
    pid_ok         = int'(in_ch.process_id) < MAX_PROCS;
    seg_ok         = int'(in_ch.segment_index) < MAX_SEGS;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        uw_en         = 1'b1;
        uw_addr       = clr_r;
        tw_en         = 1'b1;
        tw_bank       = 1'b0;
        tw_addr       = '0;
        tw_data.len   = total_r;
        cur_nxt       = 1'b0;
        count_nxt     = CNT_W'(1);
        if (clr_r == UC_AW'(UC_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + UC_AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_ch.kind;
          pid_nxt  = in_ch.process_id;
          seg_nxt  = in_ch.segment_index;
          req_nxt  = in_ch.request_length;
          mode_nxt = in_ch.fit_mode;
          case (in_ch.kind)
            vpa_pkg::K_ALLOC: begin
              if (in_ch.request_length == '0 || in_ch.request_length > total_r ||
                  in_ch.fit_mode > vpa_pkg::FIT_WORST || !pid_ok || !seg_ok) begin
                em_nxt    = '{vpa_pkg::R_ALLOC, vpa_pkg::STAT_FAIL, '0, in_ch.process_id,
                              in_ch.segment_index, in_ch.request_length, 1'b1};
                state_nxt = ST_EMIT;
              end else begin
                phase_nxt = PH_FIRST;
                go_pass   = 1'b1;
                go_type   = PASS_SCAN;
              end
            end
            vpa_pkg::K_FREE: begin
              go_pass = 1'b1;
              go_type = PASS_MERGE;
            end
            vpa_pkg::K_TOUCH: begin
              if (!pid_ok || !seg_ok) begin
                em_nxt    = '{vpa_pkg::R_TOUCH, vpa_pkg::STAT_FAIL, '0, in_ch.process_id,
                              in_ch.segment_index, '0, 1'b1};
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_UPD_RD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        rd_nxt    = rd_r + CNT_W'(1);
        state_nxt = last_rd ? ST_END : ST_RD;
        case (pass_r)
          PASS_SCAN: begin
            ent_nxt   = tdat;
            ur_addr   = uidx(tdat.owner, tdat.seg);
            rd_nxt    = rd_r;
            state_nxt = ST_USE;
          end
          PASS_COMPACT: begin
            if (tdat.used) begin
              tw_en         = 1'b1;
              tw_data       = tdat;
              tw_data.start = addr_r;
              addr_nxt      = addr_r + tdat.len;
              j_nxt         = j_r + CNT_W'(1);
            end
          end
          PASS_SPLIT: begin
            tw_en   = 1'b1;
            tw_data = tdat;
            j_nxt   = j_r + CNT_W'(1);
            if (rd_r[PI_W-1:0] == pick_idx_r) begin
              tw_data.used  = 1'b1;
              tw_data.owner = pid_r;
              tw_data.seg   = seg_r;
              tw_data.len   = req_r;
              rd_nxt        = rd_r;
              state_nxt     = ST_SPLIT2;
            end
          end
          PASS_MERGE: begin
            if (tdat.used && tdat.owner == pid_r) begin
              e.used  = 1'b0;
              rel_nxt = rel_r + tdat.len;
              if (int'(pid_r) < MAX_PROCS) begin
                uw_en   = 1'b1;
                uw_addr = uidx(pid_r, tdat.seg);
              end
            end
            if (hold_v_r && !hold_r.used && !e.used) begin
              hold_nxt.len = hold_r.len + e.len;
            end else begin
              if (hold_v_r) begin
                tw_en   = 1'b1;
                tw_data = hold_r;
                j_nxt   = j_r + CNT_W'(1);
              end
              hold_nxt   = e;
              hold_v_nxt = 1'b1;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_USE: begin
        rd_nxt    = rd_r + CNT_W'(1);
        state_nxt = last_rd ? ST_END : ST_RD;
        if (ent_r.used) begin
          if (ent_r.owner == pid_r && ent_r.seg == seg_r) begin
            conflict_nxt = 1'b1;
          end
          if (!min_found_r || urdata < min_uc_r) begin
            min_found_nxt = 1'b1;
            min_idx_nxt   = rd_r[PI_W-1:0];
            min_uc_nxt    = urdata;
            min_ent_nxt   = ent_r;
          end
        end else begin
          fs_nxt = fs_r + ent_r.len;
          if (ent_r.len >= req_r) begin
            if (!pick_found_r ||
                (mode_r == vpa_pkg::FIT_BEST && ent_r.len < pick_len_r) ||
                (mode_r == vpa_pkg::FIT_WORST && ent_r.len > pick_len_r)) begin
              pick_found_nxt = 1'b1;
              pick_idx_nxt   = rd_r[PI_W-1:0];
              pick_start_nxt = ent_r.start;
              pick_len_nxt   = ent_r.len;
            end
          end
        end
      end
      ST_SPLIT2: begin
        tw_en         = 1'b1;
        tw_data.start = pick_start_r + req_r;
        tw_data.len   = pick_len_r - req_r;
        j_nxt         = j_r + CNT_W'(1);
        rd_nxt        = rd_r + CNT_W'(1);
        state_nxt     = last_rd ? ST_END : ST_RD;
      end
      ST_END: begin
        case (pass_r)
          PASS_SCAN: begin
            if (phase_r == PH_FIRST && conflict_r) begin
              em_nxt    = '{vpa_pkg::R_ALLOC, vpa_pkg::STAT_FAIL, '0, pid_r, seg_r, req_r,
                            1'b1};
              state_nxt = ST_EMIT;
            end else if (phase_r == PH_EVICT) begin
              evict_chk = 1'b1;
            end else if (pick_found_r && pick_len_r == req_r) begin
              tw_en     = 1'b1;
              tw_bank   = cur_r;
              tw_addr   = pick_idx_r;
              tw_data   = '{1'b1, pid_r, seg_r, pick_start_r, pick_len_r};
              state_nxt = ST_UPD_RD;
            end else if (pick_found_r && count_r < MAX_CNT) begin
              go_pass = 1'b1;
              go_type = PASS_SPLIT;
            end else if (phase_r == PH_FIRST) begin
              phase_nxt = PH_AFTER;
              go_pass   = 1'b1;
              go_type   = PASS_COMPACT;
            end else if (phase_r == PH_AFTER) begin
              evict_chk = 1'b1;
            end else begin
              em_nxt    = '{vpa_pkg::R_ALLOC, vpa_pkg::STAT_FAIL, '0, pid_r, seg_r, req_r,
                            1'b1};
              state_nxt = ST_EMIT;
            end
            if (evict_chk) begin
              if (fs_r < req_r && min_found_r) begin
                tw_en        = 1'b1;
                tw_bank      = cur_r;
                tw_addr      = min_idx_r;
                tw_data      = min_ent_r;
                tw_data.used = 1'b0;
                uw_en        = 1'b1;
                uw_addr      = uidx(min_ent_r.owner, min_ent_r.seg);
                phase_nxt    = PH_EVICT;
                em_nxt       = '{vpa_pkg::R_EVICT, vpa_pkg::STAT_OK, min_ent_r.start,
                                 min_ent_r.owner, min_ent_r.seg, min_ent_r.len, 1'b0};
                state_nxt    = ST_EMIT;
              end else begin
                phase_nxt = PH_FINAL;
                go_pass   = 1'b1;
                go_type   = PASS_COMPACT;
              end
            end
          end
          PASS_COMPACT: begin
            cur_nxt   = ~cur_r;
            count_nxt = j_r;
            if (total_r > addr_r && j_r < MAX_CNT) begin
              tw_en         = 1'b1;
              tw_data.start = addr_r;
              tw_data.len   = total_r - addr_r;
              count_nxt     = j_r + CNT_W'(1);
            end
            go_pass = 1'b1;
            go_type = PASS_SCAN;
          end
          PASS_SPLIT: begin
            cur_nxt   = ~cur_r;
            count_nxt = count_r + CNT_W'(1);
            state_nxt = ST_UPD_RD;
          end
          PASS_MERGE: begin
            cur_nxt   = ~cur_r;
            count_nxt = j_r;
            if (hold_v_r) begin
              tw_en     = 1'b1;
              tw_data   = hold_r;
              count_nxt = j_r + CNT_W'(1);
            end
            em_nxt    = '{vpa_pkg::R_FREE, vpa_pkg::STAT_OK, '0, pid_r, '0, rel_r, 1'b1};
            state_nxt = ST_EMIT;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_UPD_RD: begin
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        uw_en     = 1'b1;
        uw_addr   = uidx(pid_r, seg_r);
        uw_data   = newc;
        state_nxt = ST_EMIT;
        if (kind_r == vpa_pkg::K_TOUCH) begin
          em_nxt = '{vpa_pkg::R_TOUCH, vpa_pkg::STAT_OK, '0, pid_r, seg_r, LW'(newc), 1'b1};
        end else begin
          em_nxt = '{vpa_pkg::R_ALLOC, vpa_pkg::STAT_OK, pick_start_r, pid_r, seg_r, req_r,
                     1'b1};
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = em_r;
          out_valid_nxt = 1'b1;
          if (em_r.last) begin
            state_nxt = ST_IDLE;
          end else begin
            go_pass = 1'b1;
            go_type = PASS_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (go_pass) begin
      pass_nxt       = go_type;
      rd_nxt         = '0;
      j_nxt          = '0;
      addr_nxt       = '0;
      fs_nxt         = '0;
      rel_nxt        = '0;
      hold_v_nxt     = 1'b0;
      conflict_nxt   = 1'b0;
      pick_found_nxt = 1'b0;
      min_found_nxt  = 1'b0;
      state_nxt      = (count_nxt == '0) ? ST_END : ST_RD;
    end

    if (cfg_xfer) begin
      total_nxt = cfg_ch.total_size;
      clr_nxt   = '0;
      state_nxt = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pass_r      <= PASS_SCAN;
      phase_r     <= PH_FIRST;
      cur_r       <= 1'b0;
      count_r     <= CNT_W'(1);
      rd_r        <= '0;
      j_r         <= '0;
      clr_r       <= '0;
      total_r     <= LW'(4096);
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      phase_r     <= phase_nxt;
      cur_r       <= cur_nxt;
      count_r     <= count_nxt;
      rd_r        <= rd_nxt;
      j_r         <= j_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    mode_r       <= mode_nxt;
    pid_r        <= pid_nxt;
    seg_r        <= seg_nxt;
    req_r        <= req_nxt;
    ent_r        <= ent_nxt;
    min_ent_r    <= min_ent_nxt;
    hold_r       <= hold_nxt;
    conflict_r   <= conflict_nxt;
    pick_found_r <= pick_found_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_start_r <= pick_start_nxt;
    pick_len_r   <= pick_len_nxt;
    fs_r         <= fs_nxt;
    addr_r       <= addr_nxt;
    rel_r        <= rel_nxt;
    min_found_r  <= min_found_nxt;
    min_idx_r    <= min_idx_nxt;
    min_uc_r     <= min_uc_nxt;
    em_r         <= em_nxt;
    out_r        <= out_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_r.result_kind;
  assign out_ch.status      = out_r.status;
  assign out_ch.address     = out_r.address & ADDR_MASK;
  assign out_ch.owner_out   = out_r.owner_out;
  assign out_ch.segment_out = out_r.segment_out;
  assign out_ch.length_out  = out_r.length_out;
  assign out_ch.last        = out_r.last;

endmodule

// ===== verif/tb.sv =====
// Testbench for the variable partition allocator: directed and random transfers with a
// scoreboard class that predicts every result. Depends on vpa_pkg, the channel
// interfaces and the variable_partition_allocator top level.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] K_IGNORED = 2'd3;
  localparam logic [1:0] FIT_BAD   = 2'd3;
  localparam int NPART      = 16;
  localparam int NSEG       = 8;
  localparam int SETTLE     = 100;
  localparam int QUIET_MAX  = 20000;
  localparam int HOLD_LEN   = 400;

  class alloc_scoreboard;
    int unsigned   tsize;
    int unsigned   p_start[NPART];
    int unsigned   p_len[NPART];
    bit            p_used[NPART];
    int unsigned   p_own[NPART];
    int unsigned   p_seg[NPART];
    int unsigned   n_parts;
    int unsigned   uses[128];
    vpa_pkg::res_t expected_q[$];
    int            mismatches;

    function new();
      mismatches = 0;
      set_size(4096);
    endfunction

    function void set_size(int unsigned v);
      tsize = v;
      for (int i = 0; i < NPART; i++) begin
        p_start[i] = 0; p_len[i] = 0; p_used[i] = 0; p_own[i] = 0; p_seg[i] = 0;
      end
      foreach (uses[i]) uses[i] = 0;
      p_len[0] = v;
      n_parts = 1;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void expect_result(logic [1:0] k, logic st, int unsigned a, int unsigned o,
                                int unsigned s, int unsigned l, logic lst);
      vpa_pkg::res_t r;
      r.result_kind = k; r.status = st; r.address = a[15:0]; r.owner_out = o[3:0];
      r.segment_out = s[2:0]; r.length_out = l[15:0]; r.last = lst;
      expected_q = {expected_q, r};
    endfunction

    function int fit_index(int unsigned len, logic [1:0] mode);
      int pick;
      pick = -1;
      for (int i = 0; i < n_parts; i++) begin
        if (p_used[i] || p_len[i] < len) continue;
        if (mode == vpa_pkg::FIT_FIRST) return i;
        if (pick < 0 || (mode == vpa_pkg::FIT_BEST && p_len[i] < p_len[pick]) ||
            (mode == vpa_pkg::FIT_WORST && p_len[i] > p_len[pick]))
          pick = i;
      end
      return pick;
    endfunction

    function int place(int unsigned pid, int unsigned seg, int unsigned len, logic [1:0] mode);
      int f;
      f = fit_index(len, mode);
      if (f < 0) return -1;
      if (p_len[f] != len) begin
        if (n_parts >= NPART) return -1;
        for (int k = n_parts; k > f + 1; k--) begin
          p_start[k] = p_start[k-1]; p_len[k] = p_len[k-1]; p_used[k] = p_used[k-1];
          p_own[k] = p_own[k-1]; p_seg[k] = p_seg[k-1];
        end
        p_start[f+1] = p_start[f] + len; p_len[f+1] = p_len[f] - len;
        p_used[f+1] = 0; p_own[f+1] = 0; p_seg[f+1] = 0;
        n_parts++;
        p_len[f] = len;
      end
      p_used[f] = 1; p_own[f] = pid; p_seg[f] = seg;
      return f;
    endfunction

    function void compact();
      int unsigned j, addr;
      j = 0; addr = 0;
      for (int i = 0; i < n_parts; i++) begin
        if (!p_used[i]) continue;
        p_start[j] = addr; p_len[j] = p_len[i]; p_used[j] = 1;
        p_own[j] = p_own[i]; p_seg[j] = p_seg[i];
        addr += p_len[i];
        j++;
      end
      if (tsize > addr && j < NPART) begin
        p_start[j] = addr; p_len[j] = tsize - addr; p_used[j] = 0; p_own[j] = 0; p_seg[j] = 0;
        j++;
      end
      n_parts = j;
    endfunction

    function void merge_free();
      int unsigned i;
      i = 0;
      while (i + 1 < n_parts) begin
        if (!p_used[i] && !p_used[i+1]) begin
          p_len[i] += p_len[i+1];
          for (int k = i + 1; k + 1 < n_parts; k++) begin
            p_start[k] = p_start[k+1]; p_len[k] = p_len[k+1]; p_used[k] = p_used[k+1];
            p_own[k] = p_own[k+1]; p_seg[k] = p_seg[k+1];
          end
          n_parts--;
        end else begin
          i++;
        end
      end
    endfunction

    function void note_input(logic [1:0] kind, logic [3:0] pid, logic [2:0] seg,
                             logic [15:0] len, logic [1:0] mode);
      bit ok;
      int p, m;
      int unsigned fs, released, u;
      if (kind == vpa_pkg::K_ALLOC) begin
        ok = len != 0 && len <= tsize && mode != FIT_BAD;
        for (int i = 0; ok && i < n_parts; i++)
          if (p_used[i] && p_own[i] == pid && p_seg[i] == seg) ok = 0;
        if (!ok) begin
          expect_result(vpa_pkg::R_ALLOC, vpa_pkg::STAT_FAIL, 0, pid, seg, len, 1'b1);
          return;
        end
        p = place(pid, seg, len, mode);
        if (p < 0) begin
          compact();
          p = place(pid, seg, len, mode);
        end
        if (p < 0) begin
          fs = 0;
          for (int i = 0; i < n_parts; i++) if (!p_used[i]) fs += p_len[i];
          while (fs < len) begin
            m = -1;
            for (int i = 0; i < n_parts; i++) begin
              if (!p_used[i]) continue;
              if (m < 0 || uses[p_own[i]*NSEG + p_seg[i]] < uses[p_own[m]*NSEG + p_seg[m]])
                m = i;
            end
            if (m < 0) break;
            p_used[m] = 0;
            uses[p_own[m]*NSEG + p_seg[m]] = 0;
            expect_result(vpa_pkg::R_EVICT, vpa_pkg::STAT_OK, p_start[m], p_own[m], p_seg[m],
                          p_len[m], 1'b0);
            fs += p_len[m];
          end
          compact();
          p = place(pid, seg, len, mode);
        end
        if (p < 0) begin
          expect_result(vpa_pkg::R_ALLOC, vpa_pkg::STAT_FAIL, 0, pid, seg, len, 1'b1);
        end else begin
          u = pid * NSEG + seg;
          if (uses[u] < 255) uses[u]++;
          expect_result(vpa_pkg::R_ALLOC, vpa_pkg::STAT_OK, p_start[p], pid, seg, len, 1'b1);
        end
      end else if (kind == vpa_pkg::K_FREE) begin
        released = 0;
        for (int i = 0; i < n_parts; i++) begin
          if (p_used[i] && p_own[i] == pid) begin
            p_used[i] = 0;
            uses[pid*NSEG + p_seg[i]] = 0;
            released += p_len[i];
            p_own[i] = 0; p_seg[i] = 0;
          end
        end
        merge_free();
        expect_result(vpa_pkg::R_FREE, vpa_pkg::STAT_OK, 0, pid, 0, released, 1'b1);
      end else if (kind == vpa_pkg::K_TOUCH) begin
        u = pid * NSEG + seg;
        if (uses[u] < 255) uses[u]++;
        expect_result(vpa_pkg::R_TOUCH, vpa_pkg::STAT_OK, 0, pid, seg, uses[u], 1'b1);
      end
    endfunction

    function void check(vpa_pkg::res_t got);
      vpa_pkg::res_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d status %0d addr %0d own %0d seg %0d %s %0d %0d",
                   got.result_kind, got.status, got.address, got.owner_out, got.segment_out,
                   "len/last", got.length_out, got.last);
        return;
      end
      exp = expected_q.pop_front();
      if (got.result_kind !== exp.result_kind || got.status !== exp.status ||
          got.address !== exp.address || got.owner_out !== exp.owner_out ||
          got.segment_out !== exp.segment_out || got.length_out !== exp.length_out ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected: kind %0d status %0d addr %0d own %0d seg %0d %s %0d %0d",
                   exp.result_kind, exp.status, exp.address, exp.owner_out, exp.segment_out,
                   "len/last", exp.length_out, exp.last);
          $display("         actual:   kind %0d status %0d addr %0d own %0d seg %0d %s %0d %0d",
                   got.result_kind, got.status, got.address, got.owner_out, got.segment_out,
                   "len/last", got.length_out, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;
  int   rx_hold = 0;
  int   quiet = 0;
  alloc_scoreboard sb = new();

  vpa_in_if  in_ch();
  vpa_out_if out_ch();
  vpa_cfg_if cfg_ch();

  variable_partition_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0; in_ch.kind = vpa_pkg::K_ALLOC; in_ch.process_id = '0;
    in_ch.segment_index = '0; in_ch.request_length = '0; in_ch.fit_mode = vpa_pkg::FIT_FIRST;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.total_size = '0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      vpa_pkg::res_t got;
      got.result_kind = out_ch.result_kind; got.status = out_ch.status;
      got.address = out_ch.address; got.owner_out = out_ch.owner_out;
      got.segment_out = out_ch.segment_out; got.length_out = out_ch.length_out;
      got.last = out_ch.last;
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] kind, logic [3:0] pid, logic [2:0] seg, logic [15:0] len,
                      logic [1:0] mode);
    @(negedge clk);
    in_ch.valid <= 1'b1; in_ch.kind <= kind; in_ch.process_id <= pid;
    in_ch.segment_index <= seg; in_ch.request_length <= len; in_ch.fit_mode <= mode;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(kind, pid, seg, len, mode);
    if (!calm && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  task automatic write_size(int unsigned v);
    drain();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1; cfg_ch.total_size <= v[15:0];
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_size(v);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item(int unsigned size);
    int unsigned r, len;
    logic [1:0] mode;
    r = $urandom_range(99);
    mode = ($urandom_range(99) < 95) ? 2'($urandom_range(2)) : FIT_BAD;
    if (r < 55) begin
      case ($urandom_range(19))
        0:       len = 0;
        1:       len = $urandom_range(65535);
        2, 3:    len = $urandom_range(1, size);
        default: len = $urandom_range(1, (size > 3) ? size / 3 : 1);
      endcase
      send(vpa_pkg::K_ALLOC, 4'($urandom_range(15)), 3'($urandom_range(7)), len[15:0], mode);
    end else if (r < 70) begin
      send(vpa_pkg::K_FREE, 4'($urandom_range(15)), 3'($urandom_range(7)), 16'($urandom),
           mode);
    end else if (r < 94) begin
      send(vpa_pkg::K_TOUCH, 4'($urandom_range(15)), 3'($urandom_range(7)), 16'($urandom),
           mode);
    end else begin
      send(K_IGNORED, 4'($urandom_range(15)), 3'($urandom_range(7)), 16'($urandom), mode);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(vpa_pkg::K_ALLOC, 4'd0, 3'd0, 16'd0, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_ALLOC, 4'd0, 3'd1, 16'd4097, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_ALLOC, 4'd0, 3'd2, 16'hFFFF, vpa_pkg::FIT_BEST);
    send(vpa_pkg::K_ALLOC, 4'd0, 3'd3, 16'd10, FIT_BAD);
    send(vpa_pkg::K_ALLOC, 4'd1, 3'd0, 16'd100, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_ALLOC, 4'd1, 3'd1, 16'd200, vpa_pkg::FIT_BEST);
    send(vpa_pkg::K_ALLOC, 4'd2, 3'd0, 16'd300, vpa_pkg::FIT_WORST);
    send(vpa_pkg::K_ALLOC, 4'd1, 3'd0, 16'd40, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_TOUCH, 4'd1, 3'd0, 16'd0, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_TOUCH, 4'd15, 3'd7, 16'd0, vpa_pkg::FIT_FIRST);
    send(K_IGNORED, 4'd3, 3'd3, 16'd5, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_FREE, 4'd1, 3'd0, 16'd0, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_ALLOC, 4'd3, 3'd2, 16'd50, vpa_pkg::FIT_BEST);
    send(vpa_pkg::K_ALLOC, 4'd4, 3'd3, 16'd50, vpa_pkg::FIT_WORST);
    send(vpa_pkg::K_FREE, 4'd9, 3'd0, 16'd0, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_ALLOC, 4'd5, 3'd5, 16'd4000, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_ALLOC, 4'd15, 3'd7, 16'd96, vpa_pkg::FIT_BEST);
    drain();

    calm = 1'b1;
    for (int i = 0; i < 24; i++) send(vpa_pkg::K_TOUCH, 4'd6, 3'd6, 16'd0, vpa_pkg::FIT_FIRST);
    calm = 1'b0;

    write_size(32);
    for (int i = 0; i < 15; i++)
      send(vpa_pkg::K_ALLOC, 4'(i), 3'(i), 16'd1, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_ALLOC, 4'd15, 3'd0, 16'd1, vpa_pkg::FIT_FIRST);
    send(vpa_pkg::K_ALLOC, 4'd15, 3'd1, 16'd17, vpa_pkg::FIT_BEST);
    send(vpa_pkg::K_ALLOC, 4'd15, 3'd2, 16'd5, vpa_pkg::FIT_WORST);

    write_size(64);
    for (int i = 0; i < 60; i++) begin
      if (i == 20) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        rx_hold = HOLD_LEN;
      end
      random_item(64);
    end
    drain();
    write_size(65535);
    for (int i = 0; i < 40; i++) random_item(65535);
    write_size(300);
    calm = 1'b1;
    for (int i = 0; i < 30; i++) random_item(300);
    calm = 1'b0;
    write_size(1);
    for (int i = 0; i < 12; i++) random_item(1);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vpa_pkg.sv
rtl/vpa_ifs.sv
rtl/vpa_ram.sv
rtl/variable_partition_allocator.sv
verif/tb.sv
